@@ src/pool2d_pkg.sv @@
// ----------------------------------------------------------------------------
// pool2d_pkg
// Shared constants, register codes and control types of the 2-D pooling block.
// ----------------------------------------------------------------------------
package pool2d_pkg;

	localparam int SAMPLE_BITS    = 16;
	localparam int POS_BITS       = 6;
	localparam int STRIDE_BITS    = 4;
	localparam int KSIZE_BITS     = 4;
	localparam int DIM_BITS       = 11;
	localparam int S_TDATA_BITS   = 16;
	localparam int M_TDATA_BITS   = 24;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 11;

	localparam logic [CFG_INDEX_BITS-1:0] REG_POOL_MODE    = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_KERNEL_SIZE  = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_STRIDE_STEP  = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_PLANE_WIDTH  = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_PLANE_HEIGHT = 3'd4;

	// commands from the controller to the datapath
	typedef struct packed {
		logic wr;          // write the accepted sample, advance raster position
		logic rd;          // read one window entry
		logic rd_first;    // this read is the top-left window entry
		logic rd_row_end;  // this read closes a window row
		logic div_load;    // load the divider from the window sum
		logic div_step;    // one quotient bit
		logic out_load;    // load the output register
	} pool2d_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic hit;       // current raster position completes a window
		logic avg_mode;  // average pooling selected
		logic out_busy;  // output register holds a result not yet taken
	} pool2d_stat_t;

endpackage

@@ src/pool2d_ctrl.sv @@
// ----------------------------------------------------------------------------
// pool2d_ctrl
// Sequencer: takes samples, walks a completed window, runs the divider in
// average mode and hands the result to the output register.
// ----------------------------------------------------------------------------
module pool2d_ctrl #(
	parameter int KERNEL_MAX = 8,
	parameter int SUM_W      = 22
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  pool2d_pkg::pool2d_stat_t       stat,
	input  logic [$clog2(KERNEL_MAX+1)-1:0] k_val,
	output pool2d_pkg::pool2d_cmd_t        cmd
);

	localparam int KW_W = $clog2(KERNEL_MAX + 1);
	localparam int DC_W = $clog2(SUM_W + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_READ  = 3'd1;
	localparam logic [2:0] ST_LAST  = 3'd2;
	localparam logic [2:0] ST_DLOAD = 3'd3;
	localparam logic [2:0] ST_DIV   = 3'd4;
	localparam logic [2:0] ST_OUT   = 3'd5;

	logic [2:0]      state_q, state_nxt;
	logic [KW_W-1:0] kh_q, kw_q;
	logic [DC_W-1:0] dcnt_q;
	logic [KW_W-1:0] k_last;
	logic            row_end;

	assign k_last   = k_val - KW_W'(1);
	assign row_end  = (kw_q == k_last);
	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.wr = s_tvalid;
				if (s_tvalid && stat.hit) state_nxt = ST_READ;
			end
			ST_READ: begin
				cmd.rd         = 1'b1;
				cmd.rd_first   = (kh_q == '0) && (kw_q == '0);
				cmd.rd_row_end = row_end;
				if (row_end && (kh_q == k_last)) state_nxt = ST_LAST;
			end
			ST_LAST: begin
				// last read data lands in the accumulator this cycle
				state_nxt = stat.avg_mode ? ST_DLOAD : ST_OUT;
			end
			ST_DLOAD: begin
				cmd.div_load = 1'b1;
				state_nxt    = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (dcnt_q == DC_W'(SUM_W - 1)) state_nxt = ST_OUT;
			end
			ST_OUT: begin
				if (!stat.out_busy) begin
					cmd.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			kh_q    <= '0;
			kw_q    <= '0;
			dcnt_q  <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_IDLE) begin
				kh_q <= '0;
				kw_q <= '0;
			end else if (state_q == ST_READ) begin
				if (row_end) begin
					kw_q <= '0;
					kh_q <= kh_q + KW_W'(1);
				end else begin
					kw_q <= kw_q + KW_W'(1);
				end
			end
			if (state_q == ST_DLOAD) dcnt_q <= '0;
			else if (state_q == ST_DIV) dcnt_q <= dcnt_q + DC_W'(1);
		end
	end

endmodule

@@ src/pool2d_dp.sv @@
// ----------------------------------------------------------------------------
// pool2d_dp
// Datapath: configuration registers, raster counters, line store, window
// max / sum accumulator, serial divider and output register.
// ----------------------------------------------------------------------------
module pool2d_dp #(
	parameter int KERNEL_MAX = 8,
	parameter int WIDTH_MAX  = 1024,
	parameter int HEIGHT_MAX = 1024,
	parameter int SUM_W      = 22
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_valid,
	input  logic [pool2d_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [pool2d_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	input  logic [pool2d_pkg::S_TDATA_BITS-1:0]    s_tdata,
	input  pool2d_pkg::pool2d_cmd_t                cmd,
	output pool2d_pkg::pool2d_stat_t               stat,
	output logic [$clog2(KERNEL_MAX+1)-1:0]        k_val,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic [pool2d_pkg::M_TDATA_BITS-1:0]    m_tdata,
	output logic                                   m_tlast
);

	localparam int SB     = pool2d_pkg::SAMPLE_BITS;
	localparam int PB     = pool2d_pkg::POS_BITS;
	localparam int STB    = pool2d_pkg::STRIDE_BITS;
	localparam int KW_W   = $clog2(KERNEL_MAX + 1);
	localparam int SLOT_W = (KERNEL_MAX > 1) ? $clog2(KERNEL_MAX) : 1;
	localparam int COL_W  = $clog2(WIDTH_MAX);
	localparam int ROW_W  = $clog2(HEIGHT_MAX);
	localparam int WV_W   = $clog2(WIDTH_MAX + 1);
	localparam int HV_W   = $clog2(HEIGHT_MAX + 1);
	localparam int DEPTH  = KERNEL_MAX * WIDTH_MAX;
	localparam int AW     = $clog2(DEPTH);
	localparam int KK_W   = 2 * KW_W;

	// configuration registers
	logic                                 mode_q;
	logic [pool2d_pkg::KSIZE_BITS-1:0]    ksize_q;
	logic [STB-1:0]                       stride_q;
	logic [pool2d_pkg::DIM_BITS-1:0]      pw_q, ph_q;
	logic                                 cfg_known;

	// clamped settings
	logic [STB-1:0]  s_val;
	logic [WV_W-1:0] w_val;
	logic [HV_W-1:0] h_val;

	// raster position
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [SLOT_W-1:0] slot_q;
	logic [STB-1:0]    cph_q, rph_q;
	logic              col_end, row_end, last_win;

	// window walk
	logic [COL_W-1:0]  base_col_q, rd_col_q;
	logic [SLOT_W-1:0] rd_slot_q, start_slot;
	logic              last_q;
	logic [AW-1:0]     wr_addr, rd_addr;

	logic signed [SB-1:0] mem [DEPTH];
	logic signed [SB-1:0] rd_data_s1;
	logic                 rd_vld_s1, rd_first_s1;

	logic signed [SUM_W-1:0] sum_q;
	logic signed [SB-1:0]    best_q;
	logic [KK_W-1:0]         best_pos_q, idx_q;

	// divider
	logic [KK_W-1:0]  kk, rem_q;
	logic [SUM_W-1:0] quo_q;
	logic             neg_q;
	logic [KK_W:0]    trial, trial_sub;
	logic             ge;
	logic [SB-1:0]    avg;

	logic                          m_tvalid_q, m_tlast_q;
	logic [pool2d_pkg::M_TDATA_BITS-1:0] m_tdata_q;

	always_comb begin
		unique case (cfg_index)
			pool2d_pkg::REG_POOL_MODE,
			pool2d_pkg::REG_KERNEL_SIZE,
			pool2d_pkg::REG_STRIDE_STEP,
			pool2d_pkg::REG_PLANE_WIDTH,
			pool2d_pkg::REG_PLANE_HEIGHT: cfg_known = 1'b1;
			default:                      cfg_known = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b0;
			ksize_q  <= pool2d_pkg::KSIZE_BITS'(2);
			stride_q <= STB'(2);
			pw_q     <= pool2d_pkg::DIM_BITS'(32);
			ph_q     <= pool2d_pkg::DIM_BITS'(32);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				pool2d_pkg::REG_POOL_MODE:    mode_q   <= cfg_data[0];
				pool2d_pkg::REG_KERNEL_SIZE:  ksize_q  <= cfg_data[pool2d_pkg::KSIZE_BITS-1:0];
				pool2d_pkg::REG_STRIDE_STEP:  stride_q <= cfg_data[STB-1:0];
				pool2d_pkg::REG_PLANE_WIDTH:  pw_q     <= cfg_data;
				pool2d_pkg::REG_PLANE_HEIGHT: ph_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (ksize_q == '0)                  k_val = KW_W'(1);
		else if (32'(ksize_q) > KERNEL_MAX) k_val = KW_W'(KERNEL_MAX);
		else                                k_val = KW_W'(ksize_q);

		s_val = (stride_q == '0) ? STB'(1) : stride_q;

		if (pw_q == '0)                    w_val = WV_W'(1);
		else if (32'(pw_q) > WIDTH_MAX)    w_val = WV_W'(WIDTH_MAX);
		else                               w_val = WV_W'(pw_q);

		if (ph_q == '0)                    h_val = HV_W'(1);
		else if (32'(ph_q) > HEIGHT_MAX)   h_val = HV_W'(HEIGHT_MAX);
		else                               h_val = HV_W'(ph_q);
	end

	// a window completes once the position covers the kernel and both phase counters sit at a stride multiple
	assign col_end  = (32'(col_q) + 1 >= 32'(w_val));
	assign row_end  = (32'(row_q) + 1 >= 32'(h_val));
	assign last_win = (32'(col_q) + 32'(s_val) >= 32'(w_val))
		&& (32'(row_q) + 32'(s_val) >= 32'(h_val));

	assign stat.hit = (32'(col_q) + 1 >= 32'(k_val)) && (32'(row_q) + 1 >= 32'(k_val))
		&& (cph_q == '0) && (rph_q == '0);
	assign stat.avg_mode = mode_q;
	assign stat.out_busy = m_tvalid_q && !m_tready;

	always_comb begin
		logic [31:0] t;
		t = 32'(slot_q) + KERNEL_MAX + 1 - 32'(k_val);
		if (t >= KERNEL_MAX) t = t - KERNEL_MAX;
		start_slot = SLOT_W'(t);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			slot_q <= '0;
			cph_q  <= '0;
			rph_q  <= '0;
		end else if (cfg_valid && cfg_known) begin
			// restart the plane
			col_q  <= '0;
			row_q  <= '0;
			slot_q <= '0;
			cph_q  <= '0;
			rph_q  <= '0;
		end else if (cmd.wr) begin
			if (col_end) begin
				col_q <= '0;
				cph_q <= '0;
				if (row_end) begin
					row_q  <= '0;
					slot_q <= '0;
					rph_q  <= '0;
				end else begin
					row_q  <= row_q + ROW_W'(1);
					slot_q <= (32'(slot_q) == KERNEL_MAX - 1) ? '0 : slot_q + SLOT_W'(1);
					if (32'(row_q) + 1 < 32'(k_val))   rph_q <= '0;
					else if (rph_q == s_val - STB'(1)) rph_q <= '0;
					else                               rph_q <= rph_q + STB'(1);
				end
			end else begin
				col_q <= col_q + COL_W'(1);
				if (32'(col_q) + 1 < 32'(k_val))   cph_q <= '0;
				else if (cph_q == s_val - STB'(1)) cph_q <= '0;
				else                               cph_q <= cph_q + STB'(1);
			end
		end
	end

	// window walk pointers
	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			base_col_q <= COL_W'(32'(col_q) + 1 - 32'(k_val));
			rd_col_q   <= COL_W'(32'(col_q) + 1 - 32'(k_val));
			rd_slot_q  <= start_slot;
			last_q     <= last_win;
		end else if (cmd.rd) begin
			if (cmd.rd_row_end) begin
				rd_col_q  <= base_col_q;
				rd_slot_q <= (32'(rd_slot_q) == KERNEL_MAX - 1) ? '0 : rd_slot_q + SLOT_W'(1);
			end else begin
				rd_col_q <= rd_col_q + COL_W'(1);
			end
		end
	end

	assign wr_addr = AW'(32'(slot_q) * WIDTH_MAX + 32'(col_q));
	assign rd_addr = AW'(32'(rd_slot_q) * WIDTH_MAX + 32'(rd_col_q));

	always_ff @(posedge clk) begin
		if (cmd.wr) mem[wr_addr] <= s_tdata;
		if (cmd.rd) rd_data_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1   <= 1'b0;
			rd_first_s1 <= 1'b0;
		end else begin
			rd_vld_s1   <= cmd.rd;
			rd_first_s1 <= cmd.rd_first;
		end
	end

	// running max (first in raster order wins ties) and sum
	always_ff @(posedge clk) begin
		if (rd_vld_s1) begin
			if (rd_first_s1) begin
				sum_q      <= SUM_W'(rd_data_s1);
				best_q     <= rd_data_s1;
				best_pos_q <= '0;
				idx_q      <= KK_W'(1);
			end else begin
				sum_q <= sum_q + SUM_W'(rd_data_s1);
				idx_q <= idx_q + KK_W'(1);
				if (rd_data_s1 > best_q) begin
					best_q     <= rd_data_s1;
					best_pos_q <= idx_q;
				end
			end
		end
	end

	// restoring divider on the magnitude, one quotient bit a cycle
	assign kk        = KK_W'(k_val) * KK_W'(k_val);
	assign trial     = {rem_q, quo_q[SUM_W-1]};
	assign ge        = (trial >= {1'b0, kk});
	assign trial_sub = trial - {1'b0, kk};

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			neg_q <= sum_q[SUM_W-1];
			quo_q <= sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
			rem_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= ge ? trial_sub[KK_W-1:0] : trial[KK_W-1:0];
			quo_q <= {quo_q[SUM_W-2:0], ge};
		end
	end

	assign avg = neg_q ? SB'(-quo_q) : SB'(quo_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			m_tdata_q <= {{(pool2d_pkg::M_TDATA_BITS - SB - PB){1'b0}},
				mode_q ? PB'(0) : PB'(best_pos_q),
				mode_q ? avg : best_q};
			m_tlast_q <= last_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

endmodule

@@ src/pool2d_max_average.sv @@
// ----------------------------------------------------------------------------
// pool2d_max_average
// Streaming 2-D max / average pooling over signed Q8.8 feature-map planes.
// ----------------------------------------------------------------------------
// Samples arrive in raster order, one plane after another. A sample that does
// not complete a window lets the next one in. A sample that completes a
// window placed on a stride multiple starts a walk of the window through the
// line store, one read a cycle over the single read port. In average mode
// the serial divider (SUM_W = 16 + 2*log2 KERNEL_MAX, 22 by default) then
// produces one quotient bit a cycle. The output register may wait on m_tready.
// The line store needs no clearing after reset. The result goes out with
// tlast set on the last window of the plane; planes smaller than the kernel
// give nothing. Any configuration write to a known register restarts the
// plane.
module pool2d_max_average #(
	parameter int KERNEL_MAX = 8,
	parameter int WIDTH_MAX  = 1024,
	parameter int HEIGHT_MAX = 1024
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [pool2d_pkg::S_TDATA_BITS-1:0]   s_tdata,   // [15:0] sample
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [pool2d_pkg::M_TDATA_BITS-1:0]   m_tdata,   // [15:0] pooled_value,
	                                                         // [21:16] max_position
	output logic                                  m_tlast,   // plane_done
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [pool2d_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [pool2d_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

	localparam int SUM_W = pool2d_pkg::SAMPLE_BITS + 2 * $clog2(KERNEL_MAX);
	localparam int KW_W  = $clog2(KERNEL_MAX + 1);

	pool2d_pkg::pool2d_cmd_t  cmd;
	pool2d_pkg::pool2d_stat_t stat;
	logic [KW_W-1:0]          k_val;

	assign cfg_ready = 1'b1;

	pool2d_ctrl #(
		.KERNEL_MAX (KERNEL_MAX),
		.SUM_W      (SUM_W)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.k_val    (k_val),
		.cmd      (cmd)
	);

	pool2d_dp #(
		.KERNEL_MAX (KERNEL_MAX),
		.WIDTH_MAX  (WIDTH_MAX),
		.HEIGHT_MAX (HEIGHT_MAX),
		.SUM_W      (SUM_W)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.cmd       (cmd),
		.stat      (stat),
		.k_val     (k_val),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	// a window-completing transfer blocks the input for the walk
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && stat.hit |=> !s_tready)
		else $error("input not held during window walk");

	// never overwrite a result that has not been taken
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(m_tvalid && !m_tready))
		else $error("output register overwritten");

	// store reads only happen while the input is closed
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd |-> !s_tready)
		else $error("line store read while accepting samples");

endmodule
